>>> sv/sign_flip_t_statistic_macros.svh
// Assertion macros used by the port checker.
`ifndef SIGN_FLIP_T_STATISTIC_MACROS_SVH
`define SIGN_FLIP_T_STATISTIC_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> sv/sft_pkg.sv
// ------------------------------------------------------------------------
// Sign-flip t statistic package
// Shared widths, sequencer states and the shared unit's operation codes.
// ------------------------------------------------------------------------
package sft_pkg;
    localparam int MaxCols  = 1024;
    localparam int CntW     = $clog2(MaxCols + 1);
    localparam int SumW     = 27;
    localparam int SqW      = 42;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_ACC,
        ST_SQ,
        ST_NQ,
        ST_CHK,
        ST_NUM,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_state;

    // Operations of the shared multiplier.
    typedef enum logic [1:0] {
        OP_SQ,
        OP_NQ,
        OP_NUM
    } t_mul_op;
endpackage

>>> sv/sft_mul.sv
// ------------------------------------------------------------------------
// Shared multiplier
// One registered product of up to 64 by 11 bits; its results are used for n*Q and
// S^2*(n-1) in turn.
// ------------------------------------------------------------------------
module sft_mul (
    input  logic        i_clk,
    input  logic [63:0] i_a,
    input  logic [10:0] i_b,
    output logic [74:0] o_p
);
    logic [74:0] r_p;

    // Product register.
    always_ff @(posedge i_clk) begin
        r_p <= {11'd0, i_a} * {64'd0, i_b};
    end

    assign o_p = r_p;
endmodule

>>> sv/sign_flip_t_statistic.sv
// ------------------------------------------------------------------------
// Sign-flip t statistic
// Accumulates S, Q and n over a row, then forms the t statistic with one
// shared multiplier, a radix-2 divider and a bit-pair square root.
// ------------------------------------------------------------------------
// A sample that does not end a row leaves the input ready for the next one.
// A row-ending sample stalls the input while the divider runs
// one quotient bit per cycle over 128 bits and the root one result bit per cycle.
// The next row is accepted while a result waits; its own result holds in the
// last step until the output register is free.
// Synchronous active-low reset clears the sums, count and sequencer.
module sign_flip_t_statistic (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] sample
    input  logic        s_axis_tuser,  // sign_neg
    input  logic        s_axis_tlast,  // last_in_row
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] t_stat
    output logic        m_axis_tuser   // degenerate
);
    import sft_pkg::*;

    t_state r_state, n_state;
    logic signed [SumW-1:0] r_s;
    logic [SqW-1:0]   r_q;
    logic [CntW-1:0]  r_n;
    logic [63:0]      r_s2, r_den, r_rem, r_qt, r_v, r_res, r_bit;
    logic [127:0]     r_numr;
    logic [6:0]       r_i;
    logic             r_sat, r_neg;
    logic             r_ovalid;
    logic [31:0]      r_t;
    logic             r_dg;

    logic [63:0] w_a;
    logic [10:0] w_b;
    logic [74:0] w_p;
    t_mul_op     w_op;

    logic signed [16:0] w_v;
    logic [26:0] w_mag;
    logic [64:0] w_r1;
    logic [63:0] w_qn;
    logic [63:0] w_rb;
    logic        w_out_free;

    // Flipped sample.
    assign w_v = s_axis_tuser ? -{s_axis_tdata[15], s_axis_tdata}
                              : {s_axis_tdata[15], s_axis_tdata};
    assign w_mag = r_s[SumW-1] ? 27'(-r_s) : 27'(r_s);

    // Shared multiplier operand selection.
    always_comb begin
        case (r_state)
            ST_ACC:        w_op = OP_SQ;
            ST_SQ, ST_NQ:  w_op = OP_NQ;
            default:       w_op = OP_NUM;
        endcase
        case (w_op)
            OP_SQ:   begin w_a = {37'd0, w_mag}; w_b = w_mag[10:0]; end
            OP_NQ:   begin w_a = {22'd0, r_q};   w_b = r_n; end
            default: begin w_a = r_s2;           w_b = r_n - 11'd1; end
        endcase
    end

    sft_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_p(w_p));

    // Squaring of a 27-bit magnitude needs the full width, done directly.
    logic [53:0] w_sq;
    assign w_sq = w_mag * w_mag;

    // Divider and root step logic.
    assign w_r1 = {r_rem, r_numr[127]};
    assign w_qn = {r_qt[62:0], (w_r1 >= {1'b0, r_den})};
    assign w_rb = r_res + r_bit;

    // The output register can take a new result when empty or being drained.
    assign w_out_free = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == ST_ACC);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACC:  if (s_axis_tvalid && s_axis_tready && s_axis_tlast) n_state = ST_SQ;
            ST_SQ:   n_state = ST_NQ;
            ST_NQ:   n_state = ST_CHK;
            ST_CHK:  n_state = ST_NUM;
            ST_NUM:  n_state = ST_DIV;
            ST_DIV:  if (r_i == 7'd127) n_state = ST_SQRT;
            ST_SQRT: if (r_bit == 64'd1) n_state = ST_OUT;
            ST_OUT:  if (w_out_free) n_state = ST_ACC;
            default: n_state = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_ACC;
            r_s      <= '0;
            r_q      <= '0;
            r_n      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && w_out_free) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                ST_ACC: begin
                    if (s_axis_tvalid && s_axis_tready && (r_n < CntW'(MaxCols))) begin
                        r_s <= r_s + SumW'(w_v);
                        r_q <= r_q + SqW'(34'(w_v * w_v));
                        r_n <= r_n + 1'b1;
                    end
                end
                ST_SQ: begin
                    r_s2  <= {10'd0, w_sq};
                    r_neg <= r_s[SumW-1];
                end
                ST_CHK: begin
                    // n*Q product is now registered.
                    r_dg  <= (r_n < 11'd2) || (w_p[63:0] <= r_s2);
                    r_den <= w_p[63:0] - r_s2;
                end
                ST_NUM: begin
                    r_numr <= {32'd0, w_p[63:0], 32'd0};
                    r_rem  <= '0;
                    r_qt   <= '0;
                    r_sat  <= 1'b0;
                    r_i    <= '0;
                end
                ST_DIV: begin
                    r_numr <= r_numr << 1;
                    r_rem  <= (w_r1 >= {1'b0, r_den}) ? 64'(w_r1 - {1'b0, r_den})
                                                        : w_r1[63:0];
                    if (!r_sat) begin
                        r_qt <= w_qn;
                        if (w_qn >= 64'h4000_0000_0000_0000) r_sat <= 1'b1;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == 7'd127) begin
                        r_res <= '0;
                        r_bit <= 64'h4000_0000_0000_0000;
                        r_v   <= (r_sat || w_qn >= 64'h4000_0000_0000_0000)
                                 ? 64'h4000_0000_0000_0000 : w_qn;
                    end
                end
                ST_SQRT: begin
                    if (r_v >= w_rb) begin
                        r_v   <= r_v - w_rb;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_s <= '0;
                        r_q <= '0;
                        r_n <= '0;
                        if (r_dg) r_t <= '0;
                        else if (r_neg) r_t <= (r_res >= 64'h8000_0000) ? 32'h8000_0000
                                               : 32'(-r_res[31:0]);
                        else r_t <= (r_res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_res[31:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) m_axis_tuser <= r_dg;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_t;
endmodule

>>> sv/sft_checker.sv
// ------------------------------------------------------------------------
// Sign-flip t statistic port checker
// Watches the top-level ports for handshake and sequencing slips.
// ------------------------------------------------------------------------
`include "sign_flip_t_statistic_macros.svh"
module sft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    // A row end starts the computation, so input stalls next cycle.
    `SFT_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
    // A stalled result stays valid and unchanged.
    `SFT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // A degenerate result carries zero.
    `SFT_ASSERT_IMP(a_deg, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0)
endmodule

bind sign_flip_t_statistic sft_checker u_chk (.*);
